// File: hdl/bpra_pkg.sv
// Package for the bitmap page-run allocator: sizes, codes and shared types.
// Used by the controller, the datapath and the top level.
`default_nettype none
package bpra_pkg;
   localparam int NUM_PAGES = 4096;
   localparam int PAGE_W    = $clog2(NUM_PAGES);
   localparam int LEN_W     = PAGE_W + 1;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_RUN   = 2'd1,
      ST_BOUNDS   = 2'd2,
      ST_NULL_PG  = 2'd3
   } status_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic clear_step; // clear one bitmap entry after reset
      logic load;      // capture request and decide on the immediate checks
      logic scan_init; // start a scan at the given lower bound
      logic scan_step; // examine one page
      logic fill_init; // start writing the range
      logic fill_step; // write one page
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_last; // last entry of the clearing pass
      logic early_done; // result known without scanning
      logic is_free;    // request is a free
      logic scan_hit;
      logic scan_end;   // scan reached its end without a hit
      logic pass_one;   // current scan is the first pass
      logic fill_last;
   } stat_type;
endpackage
`default_nettype wire

// File: hdl/bpra_datapath.sv
// Datapath of the page-run allocator: free bitmap, pointer, scan counters.
// Depends on bpra_pkg; driven by bpra_ctrl.
`default_nettype none
module bpra_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bpra_pkg::cmd_type           cmd,
   output bpra_pkg::stat_type               stat,
   input  wire logic                        req_op,
   input  wire logic [bpra_pkg::PAGE_W-1:0] req_page,
   input  wire logic [bpra_pkg::LEN_W-1:0]  req_len,
   input  wire logic [bpra_pkg::LEN_W-1:0]  tracked,
   output logic [1:0]                       res_status,
   output logic [bpra_pkg::PAGE_W-1:0]      res_page
);
   import bpra_pkg::*;

   // One bit per page, 1 means free; cleared to all used by a pass after reset.
   logic                  map_mem [NUM_PAGES];
   logic                  rd_ff;
   logic [PAGE_W-1:0]     clr_ff;
   logic [PAGE_W-1:0]     ptr_ff;
   logic                  op_ff;
   logic [PAGE_W-1:0]     page_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      lim_ff;
   logic [LEN_W-1:0]      idx_ff;   // page being examined
   logic [LEN_W-1:0]      cnt_ff;   // free run length so far
   logic [LEN_W-1:0]      hi_ff;    // exclusive bound on start
   logic                  pass1_ff;
   logic [LEN_W-1:0]      pos_ff;   // fill position
   logic [LEN_W-1:0]      end_ff;   // fill end
   logic [1:0]            status_ff;
   logic [PAGE_W-1:0]     gpage_ff;

   logic [LEN_W-1:0]  lim_c, cnt_nx, start_c, ptr_ext;
   logic [LEN_W:0]    sum_c;
   logic [PAGE_W-1:0] rd_addr, wr_addr;
   logic              wr_en, wr_data, bit_c, hit_c;

   always_comb begin
      lim_c   = (tracked > LEN_W'(NUM_PAGES)) ? LEN_W'(NUM_PAGES) : tracked;
      sum_c   = (LEN_W+1)'(req_page) + (LEN_W+1)'(req_len);
      ptr_ext = LEN_W'(ptr_ff);
      // The read address runs one page ahead so that the registered bit
      // belongs to the page examined in the next cycle.
      if (cmd.scan_init) rd_addr = pass1_ff ? ptr_ff : '0;
      else if (cmd.scan_step) rd_addr = idx_ff[PAGE_W-1:0] + PAGE_W'(1);
      else rd_addr = idx_ff[PAGE_W-1:0];
      wr_en   = cmd.clear_step || cmd.fill_step;
      wr_addr = cmd.clear_step ? clr_ff : pos_ff[PAGE_W-1:0];
      wr_data = !cmd.clear_step && (op_ff == OP_FREE);
      bit_c   = (idx_ff < lim_ff) ? rd_ff : 1'b0;
      cnt_nx  = bit_c ? cnt_ff + LEN_W'(1) : '0;
      start_c = idx_ff + LEN_W'(1) - len_ff;
      hit_c   = bit_c && (cnt_nx >= len_ff) && (start_c < hi_ff);
      stat.scan_hit   = hit_c;
      stat.scan_end   = (idx_ff >= lim_ff) || (bit_c && cnt_nx >= len_ff && !hit_c);
      stat.pass_one   = pass1_ff;
      stat.fill_last  = (pos_ff + LEN_W'(1) >= end_ff);
      stat.is_free    = (op_ff == OP_FREE);
      stat.early_done = (status_ff != ST_OK);
      stat.clear_last = (clr_ff == PAGE_W'(NUM_PAGES - 1));
      res_status      = status_ff;
      res_page        = gpage_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         idx_ff    <= '0;
         ptr_ff    <= '0;
         status_ff <= ST_OK;
         gpage_ff  <= '0;
         pass1_ff  <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + PAGE_W'(1);
         if (cmd.load) begin
            op_ff    <= req_op;
            page_ff  <= req_page;
            len_ff   <= req_len;
            lim_ff   <= lim_c;
            gpage_ff <= '0;
            pass1_ff <= (ptr_ext < lim_c);
            if (req_len == '0) status_ff <= ST_BOUNDS;
            else if (req_op == OP_ALLOC) status_ff <= (req_len > lim_c) ? ST_NO_RUN : ST_OK;
            else if (sum_c > (LEN_W+1)'(lim_c)) status_ff <= ST_BOUNDS;
            else if (req_page == '0) status_ff <= ST_NULL_PG;
            else status_ff <= ST_OK;
         end
         if (cmd.scan_init) begin
            // First pass from the pointer; second pass from page 0 below it.
            idx_ff <= pass1_ff ? ptr_ext : '0;
            hi_ff  <= pass1_ff ? lim_ff : ptr_ext;
            cnt_ff <= '0;
         end
         if (cmd.scan_step) begin
            idx_ff <= idx_ff + LEN_W'(1);
            cnt_ff <= cnt_nx;
            if (hit_c) begin
               pos_ff   <= start_c;
               end_ff   <= start_c + len_ff;
               gpage_ff <= start_c[PAGE_W-1:0];
            end else if (stat.scan_end) begin
               if (pass1_ff) pass1_ff <= 1'b0;
               else status_ff <= ST_NO_RUN;
            end
         end
         if (cmd.fill_init) begin
            pos_ff <= LEN_W'(page_ff);
            end_ff <= LEN_W'(page_ff) + len_ff;
            ptr_ff <= page_ff;
         end
         if (cmd.fill_step) begin
            pos_ff <= pos_ff + LEN_W'(1);
            if (stat.fill_last && op_ff == OP_ALLOC)
               ptr_ff <= (end_ff >= lim_ff) ? '0 : end_ff[PAGE_W-1:0];
         end
      end
   end
endmodule
`default_nettype wire

// File: hdl/bpra_ctrl.sv
// Controller of the page-run allocator: sequences clear, check, scan, fill, reply.
// Depends on bpra_pkg; commands bpra_datapath.
`default_nettype none
module bpra_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_fire,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output bpra_pkg::cmd_type        cmd,
   input  wire bpra_pkg::stat_type  stat
);
   import bpra_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_CHECK = 7'b0000100,
      S_SINIT = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_FILL  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_fire;
            if (req_fire) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.early_done) state_in = S_RESP;
            else if (stat.is_free) begin
               cmd.fill_init = 1'b1;
               state_in = S_FILL;
            end else state_in = S_SINIT;
         end
         S_SINIT: begin
            cmd.scan_init = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) state_in = S_FILL;
            else if (stat.scan_end) state_in = stat.pass_one ? S_SINIT : S_RESP;
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// File: hdl/bitmap_page_run_allocator.sv
// Top level of the next-fit bitmap page-run allocator.
// Depends on bpra_pkg, bpra_ctrl and bpra_datapath.
//
//   channel   direction  payload
//   req_      in         tdata: operation, start_page, run_length
//   rsp_      out        tdata: status, granted_page
//   csr_      in         data: tracked_pages
//
// One request at a time: a new request is accepted only after the reply is taken.
// A free is checked and then writes its range page by page before it replies; a
// request that fails its checks replies right after the check. An allocation scans
// one page per cycle over at most two passes, then writes the run that it found.
// After reset the bitmap is cleared to all used, page by page, with req_tready low.
// A stalled reply holds its data; csr_ready is always high.
`default_nettype none
module bitmap_page_run_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // operation[0], start_page[12:1], run_length[25:13]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // status[1:0], granted_page[13:2]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data    // tracked_pages[12:0]
);
   import bpra_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [LEN_W-1:0]  tracked_ff;
   logic [1:0]        st;
   logic [PAGE_W-1:0] gp;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) tracked_ff <= LEN_W'(4096);
      else if (csr_valid) tracked_ff <= csr_data[LEN_W-1:0];
   end

   bpra_ctrl u_ctrl (
      .clock, .reset,
      .req_fire (req_tvalid && req_tready),
      .req_ready(req_tready),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .cmd, .stat
   );

   bpra_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .req_op    (req_tdata[0]),
      .req_page  (req_tdata[12:1]),
      .req_len   (req_tdata[25:13]),
      .tracked   (tracked_ff),
      .res_status(st),
      .res_page  (gp)
   );

   assign rsp_tdata = {2'b00, gp, st};
endmodule
`default_nettype wire

// File: verif/bitmap_page_run_allocator_test.sv
// Self-checking testbench for the next-fit bitmap page-run allocator.
// Depends on bpra_pkg and bitmap_page_run_allocator. A built-in allocator model
// predicts each reply, and the replies are checked in order under random stalls.
`default_nettype none
module bitmap_page_run_allocator_test;
   import bpra_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type  status;
      logic [11:0] page;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // operation[0], start_page[12:1], run_length[25:13]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // status[1:0], granted_page[13:2]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;   // tracked_pages[12:0]

   bit          page_free [NUM_PAGES];
   logic [11:0] next_fit;
   int          tracked_cfg;
   reply_type   pending_replies[$];
   int          error_count;
   int          status_seen [4];
   int          request_count;
   int          stall_token;
   bit          no_gaps;

   bitmap_page_run_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Lowest start in [lo, hi) of a free run of len pages inside the first t pages.
   function automatic void find_free_run(input int lo, input int hi, input int len,
                                         input int t, output bit hit, output int start);
      int count;
      count = 0;
      hit = 0;
      start = 0;
      for (int i = lo; i < t; i++) begin
         if (page_free[i]) begin
            count++;
            if (count >= len) begin
               if (i + 1 - len < hi) begin
                  hit = 1;
                  start = i + 1 - len;
               end
               return;
            end
         end else begin
            count = 0;
         end
      end
   endfunction

   function automatic reply_type allocator_step(op_type op, logic [11:0] page,
                                                logic [12:0] len);
      reply_type r;
      int t, p, s, nxt;
      bit hit;
      r.status = ST_OK;
      r.page = '0;
      t = (tracked_cfg > NUM_PAGES) ? NUM_PAGES : tracked_cfg;
      if (len == 0) begin
         r.status = ST_BOUNDS;
      end else if (op == OP_ALLOC) begin
         p = next_fit;
         hit = 0;
         if (len > t) begin
            r.status = ST_NO_RUN;
         end else begin
            if (p < t) find_free_run(p, t, len, t, hit, s);
            if (!hit) find_free_run(0, p, len, t, hit, s);
            if (hit) begin
               nxt = s + len;
               for (int i = s; i < nxt; i++) page_free[i] = 0;
               next_fit = (nxt >= t || nxt > 4095) ? 12'd0 : 12'(nxt);
               r.page = 12'(s);
            end else begin
               r.status = ST_NO_RUN;
            end
         end
      end else begin
         if (int'(page) + int'(len) > t) begin
            r.status = ST_BOUNDS;
         end else if (page == 0) begin
            r.status = ST_NULL_PG;
         end else begin
            for (int i = page; i < page + len; i++) page_free[i] = 1;
            next_fit = page;
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Valid drops after each request; the block is busy then anyway.
   task automatic send_request(op_type op, logic [11:0] page, logic [12:0] len);
      repeat (pick_gap() + 1) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, len, page, op};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      pending_replies.push_back(allocator_step(op, page, len));
      request_count++;
   endtask

   task automatic wait_idle();
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_tracked(logic [12:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= {3'b0, value};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracked_cfg = value;
   endtask

   // Reply checker.
   always @(posedge clock) begin
      reply_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $error("reply with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            e = pending_replies.pop_front();
            status_seen[rsp_tdata[1:0]]++;
            if (rsp_tdata[1:0] !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[13:2] !== e.page) begin
               $error("granted_page expected %0d got %0d", e.page, rsp_tdata[13:2]);
               error_count++;
            end
         end
      end
   end

   // Reply side: random stall patterns, plus a long hold when the test asks.
   initial begin
      int seen, hold, mode, mode_left;
      seen = 0;
      hold = 0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (stall_token != seen) begin
            seen = stall_token;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   task automatic test_directed_default();
      send_request(OP_ALLOC, 12'd0, 13'd1);       // empty map: no run
      send_request(OP_FREE, 12'd0, 13'd4096);     // in bounds but null page
      send_request(OP_FREE, 12'd1, 13'd4096);     // past the end
      send_request(OP_ALLOC, 12'd0, 13'd0);       // zero length
      send_request(OP_FREE, 12'd5, 13'd0);
      send_request(OP_FREE, 12'd4095, 13'd1);     // last page
      send_request(OP_ALLOC, 12'd0, 13'd1);       // ends at the top, pointer wraps
      send_request(OP_FREE, 12'd1, 13'd4095);
      send_request(OP_FREE, 12'd100, 13'd4);      // double free
      send_request(OP_ALLOC, 12'hfff, 13'd4096);  // page 0 is never free
      send_request(OP_ALLOC, 12'd0, 13'd8);       // first-pass search from page 100
      send_request(OP_ALLOC, 12'd0, 13'd4088);
      send_request(OP_FREE, 12'd2048, 13'd10);
      send_request(OP_ALLOC, 12'd0, 13'd5);
      send_request(OP_ALLOC, 12'd0, 13'd6);       // run found right at the pointer
   endtask

   task automatic test_config_extremes();
      write_tracked(13'd1);
      send_request(OP_ALLOC, 12'd0, 13'd1);
      send_request(OP_ALLOC, 12'd0, 13'd2);       // longer than tracked space
      send_request(OP_FREE, 12'd0, 13'd1);
      send_request(OP_FREE, 12'd1, 13'd1);
      write_tracked(13'h1fff);                    // saturates to the page count
      send_request(OP_FREE, 12'd4000, 13'd96);
      send_request(OP_ALLOC, 12'd0, 13'd96);
      write_tracked(13'd64);                      // pointer is back at page 0
      send_request(OP_FREE, 12'd3, 13'd2);
      send_request(OP_ALLOC, 12'd0, 13'd64);
   endtask

   task automatic random_request(int t);
      int r, page, len;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, t / 2 + 1)
                                           : $urandom_range(1, 8);
         send_request(OP_ALLOC, 12'($urandom), 13'(len));
      end else if (r < 90 && t > 1) begin
         page = $urandom_range(1, t - 1);
         len = $urandom_range(1, (t - page < 12) ? t - page : 12);
         send_request(OP_FREE, 12'(page), 13'(len));
      end else begin
         send_request(op_type'($urandom_range(0, 1)), 12'($urandom),
                      ($urandom_range(0, 3) == 0) ? 13'd0 : 13'($urandom));
      end
   endtask

   task automatic test_random_phases();
      int t;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: t = 64;
            1: t = $urandom_range(65, 255);
            2: t = $urandom_range(2, 40);
            default: t = $urandom_range(64, 200);
         endcase
         write_tracked(13'(t));
         no_gaps = (phase % 3 == 2);
         repeat (165) random_request(t);
      end
      no_gaps = 0;
   endtask

   task automatic test_reply_backpressure();
      write_tracked(13'd128);
      stall_token++;
      no_gaps = 1;
      send_request(OP_FREE, 12'd10, 13'd20);
      repeat (6) send_request(OP_ALLOC, 12'd0, 13'd3);
      no_gaps = 0;
   endtask

   initial begin
      for (int i = 0; i < NUM_PAGES; i++) page_free[i] = 0;
      next_fit = '0;
      tracked_cfg = NUM_PAGES;
      error_count = 0;
      request_count = 0;
      stall_token = 0;
      no_gaps = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_default();
      test_config_extremes();
      test_reply_backpressure();
      test_random_phases();
      for (int w = 0; w < 200000 && pending_replies.size() != 0; w++) @(posedge clock);
      repeat (50) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $error("%0d replies never arrived", pending_replies.size());
         error_count++;
      end
      $display("Sent %0d requests over several page limits; replies ok %0d, no run %0d,",
               request_count, status_seen[0], status_seen[1]);
      $display("out of bounds %0d, null page %0d.", status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("bitmap_page_run_allocator: match");
      end else begin
         $display("bitmap_page_run_allocator: mismatch");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("bitmap_page_run_allocator: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
hdl/bpra_pkg.sv
hdl/bpra_datapath.sv
hdl/bpra_ctrl.sv
hdl/bitmap_page_run_allocator.sv
verif/bitmap_page_run_allocator_test.sv
